/* sv/tsq_pkg.sv */
// Shared types, constants and helpers for the thick segment quad tessellator.
// No dependencies; every other file but tsq_checker refers to it by scoped names.
`default_nettype none
package tsq_pkg;

  localparam int unsigned COORD_W     = 32;  // Q16.16 coordinates
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned DELTA_W     = COORD_W + 1;
  localparam int unsigned MAG_W       = COORD_W;
  localparam int unsigned UNIT_W      = 31;  // |u| in Q1.30, at most 2^30
  localparam int unsigned UNIT_FRAC   = 30;
  localparam int unsigned WIDTH_W     = COORD_W - 1;  // positive width magnitude
  localparam int unsigned PROD_W      = 62;
  localparam int unsigned SUMSQ_W     = 64;
  localparam int unsigned ROOT_W      = 32;
  localparam int unsigned SQ_REM_W    = ROOT_W + 3;
  localparam int unsigned NUM_W       = 62;
  localparam int unsigned NUM_LOW_W   = NUM_W - UNIT_W;
  localparam int unsigned SQRT_STEPS  = ROOT_W;
  localparam int unsigned DIV_STEPS   = UNIT_W;
  localparam int unsigned STEP_CNT_W  = 5;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned VTX_IDX_W   = 3;
  localparam logic [VTX_IDX_W-1:0] VTX_LAST = 3'd5;
  // Per vertex index (bit k): A0 B0 A1 B0 B1 A1
  localparam logic [5:0] VTX_END_MASK  = 6'b110100;
  localparam logic [5:0] VTX_PLUS_MASK = 6'b100101;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } tsq_color_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic [WIDTH_W-1:0]        width;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    tsq_color_t                color;
  } tsq_seg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    tsq_color_t                color;
  } tsq_job_t;

  typedef enum logic [3:0] {
    CORE_IDLE, CORE_NORM, CORE_SQX, CORE_SQY, CORE_SQRT,
    CORE_DSET, CORE_DIV, CORE_MULX, CORE_MULY, CORE_OFS, CORE_DONE
  } tsq_core_state_t;

  // p + o or p - o, clamped to the 32 bit range
  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] p,
    input logic signed [COORD_W-1:0] o,
    input logic                      sub
  );
    logic signed [COORD_W:0] po;
    logic signed [COORD_W:0] s;
    po = {o[COORD_W-1], o};
    s  = {p[COORD_W-1], p} + (sub ? -po : po);
    if (s[COORD_W] != s[COORD_W-1]) begin
      sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_add = s[COORD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* sv/tsq_if.sv */
// Valid/ready channel interfaces: segment input and vertex output.
// Depends on tsq_pkg for field widths.
`default_nettype none
interface tsq_seg_if;
  logic valid;
  logic ready;
  logic signed [tsq_pkg::COORD_W-1:0] start_x;
  logic signed [tsq_pkg::COORD_W-1:0] start_y;
  logic signed [tsq_pkg::COORD_W-1:0] end_x;
  logic signed [tsq_pkg::COORD_W-1:0] end_y;
  logic signed [tsq_pkg::COORD_W-1:0] stroke_width;
  logic [tsq_pkg::COLOR_W-1:0] color_red;
  logic [tsq_pkg::COLOR_W-1:0] color_green;
  logic [tsq_pkg::COLOR_W-1:0] color_blue;
  logic [tsq_pkg::COLOR_W-1:0] color_alpha;
  modport source(output valid, start_x, start_y, end_x, end_y, stroke_width,
                 color_red, color_green, color_blue, color_alpha, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, stroke_width,
               color_red, color_green, color_blue, color_alpha, output ready);
endinterface

interface tsq_vtx_if;
  logic valid;
  logic ready;
  logic signed [tsq_pkg::COORD_W-1:0] vertex_x;
  logic signed [tsq_pkg::COORD_W-1:0] vertex_y;
  logic [tsq_pkg::COLOR_W-1:0] out_red;
  logic [tsq_pkg::COLOR_W-1:0] out_green;
  logic [tsq_pkg::COLOR_W-1:0] out_blue;
  logic [tsq_pkg::COLOR_W-1:0] out_alpha;
  logic last_vertex;
  modport source(output valid, vertex_x, vertex_y, out_red, out_green, out_blue,
                 out_alpha, last_vertex, input ready);
  modport sink(input valid, vertex_x, vertex_y, out_red, out_green, out_blue,
               out_alpha, last_vertex, output ready);
endinterface
`default_nettype wire

/* sv/thick_segment_quad_tessellator.sv */
// Thick segment quad tessellator top level.
// Depends on tsq_pkg, tsq_if, tsq_front, tsq_queue, tsq_core and tsq_emit.
//
// Use:
//   seg (sink) takes one segment per beat: start/end points, stroke width
//   (Q16.16) and an RGBA color. vtx (source) gives six vertex beats per
//   segment, A0 B0 A1 B0 B1 A1, last_vertex high on the sixth; color is
//   copied to each vertex. A segment with width <= 0 or equal endpoints
//   is dropped at the front end and gives no beats.
//   The front end only forms deltas and pushes into a QUEUE_DEPTH deep
//   queue, so seg stays ready while the queue has room.
//   The math core works on one segment at a time: it pops the segment,
//   normalizes the magnitudes, squares them with the shared multiplier,
//   runs 32 square-root steps, sets up and runs 31 divide steps (both
//   unit components at once), forms the offsets with the multiplier and
//   hands the job to the emitter; it pops the next segment only after
//   the emitter has taken the job.
//   The emitter holds one finished job and, while vtx.ready is high, sends
//   one vertex per cycle as the core already works on the next segment.
//   When vtx.ready is low the output register holds its beat; the core
//   then waits in its done state and the queue fills, after which seg.ready
//   drops. Reset (synchronous, active high) empties the queue and returns
//   core and emitter to idle; no beat is in flight after it.
`default_nettype none
module thick_segment_quad_tessellator #(
  parameter int unsigned QUEUE_DEPTH = tsq_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  tsq_seg_if.sink   seg,
  tsq_vtx_if.source vtx
);
  logic              q_full, q_empty, push, pop;
  tsq_pkg::tsq_seg_t push_data, pop_data;
  logic              job_valid, job_take;
  tsq_pkg::tsq_job_t job;

  tsq_front u_front (
    .seg       (seg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  tsq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  tsq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  tsq_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .core_valid (job_valid),
    .core_job   (job),
    .take       (job_take),
    .vtx        (vtx)
  );
endmodule
`default_nettype wire

/* sv/tsq_front.sv */
// Front end: takes segment beats, forms the deltas and drops degenerate ones.
// Depends on tsq_pkg and tsq_if.
`default_nettype none
module tsq_front (
  tsq_seg_if.sink              seg,
  input  logic                 q_full,
  output logic                 push,
  output tsq_pkg::tsq_seg_t    push_data
);
  logic signed [tsq_pkg::DELTA_W-1:0] dx;
  logic signed [tsq_pkg::DELTA_W-1:0] dy;
  logic keep;

  assign dx = {seg.end_x[tsq_pkg::COORD_W-1], seg.end_x}
            - {seg.start_x[tsq_pkg::COORD_W-1], seg.start_x};
  assign dy = {seg.end_y[tsq_pkg::COORD_W-1], seg.end_y}
            - {seg.start_y[tsq_pkg::COORD_W-1], seg.start_y};
  // width must be positive and the segment non-empty
  assign keep = !seg.stroke_width[tsq_pkg::COORD_W-1] && (seg.stroke_width != '0)
             && ((dx != '0) || (dy != '0));

  assign seg.ready = !q_full;
  assign push      = seg.valid && !q_full && keep;

  always_comb begin
    push_data.x0    = seg.start_x;
    push_data.y0    = seg.start_y;
    push_data.x1    = seg.end_x;
    push_data.y1    = seg.end_y;
    push_data.width = seg.stroke_width[tsq_pkg::WIDTH_W-1:0];
    push_data.dx    = dx;
    push_data.dy    = dy;
    push_data.color = '{red: seg.color_red, green: seg.color_green,
                        blue: seg.color_blue, alpha: seg.color_alpha};
  end
endmodule
`default_nettype wire

/* sv/tsq_queue.sv */
// Small FIFO of classified segments between front end and math core.
// Depends on tsq_pkg.
`default_nettype none
module tsq_queue #(
  parameter int unsigned DEPTH = tsq_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tsq_pkg::tsq_seg_t push_data,
  output logic              full,
  input  logic              pop,
  output tsq_pkg::tsq_seg_t pop_data,
  output logic              empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tsq_pkg::tsq_seg_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end
endmodule
`default_nettype wire

/* sv/tsq_core.sv */
// Math core: normalize, length by bit-serial square root, unit vector by
// bit-serial division, offsets by one shared multiplier. Depends on tsq_pkg.
`default_nettype none
module tsq_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  tsq_pkg::tsq_seg_t q_data,
  output logic              q_pop,
  output logic              job_valid,
  output tsq_pkg::tsq_job_t job,
  input  logic              job_take
);
  localparam int unsigned MW = tsq_pkg::MAG_W;
  localparam int unsigned UW = tsq_pkg::UNIT_W;

  tsq_pkg::tsq_core_state_t state, state_next;

  logic signed [tsq_pkg::COORD_W-1:0] x0, y0, x1, y1, ox, oy;
  logic [tsq_pkg::WIDTH_W-1:0] width;
  tsq_pkg::tsq_color_t color;
  logic nx, ny;
  logic [MW-1:0] mx, my, mor;
  logic [tsq_pkg::SUMSQ_W-1:0] acc, sq_n;
  logic [tsq_pkg::SQ_REM_W-1:0] sq_rem, sq_rem_sh, sq_trial;
  logic [tsq_pkg::ROOT_W-1:0] root;
  logic [tsq_pkg::STEP_CNT_W-1:0] cnt;
  logic [tsq_pkg::ROOT_W-1:0] remx, remy;
  logic [tsq_pkg::NUM_LOW_W-1:0] lowx, lowy;
  logic [tsq_pkg::ROOT_W:0] rx_sh, ry_sh;
  logic [UW-1:0] qx, qy;
  logic [tsq_pkg::NUM_W-1:0] numx, numy;
  logic [UW-1:0] mul_a, mul_b;
  logic [tsq_pkg::PROD_W-1:0] mul_p, prod;
  logic [tsq_pkg::PROD_W:0] rnd;
  logic [tsq_pkg::COORD_W-1:0] ofs_mag;
  logic [tsq_pkg::DELTA_W-1:0] adx, ady;

  assign mor = mx | my;
  assign adx = q_data.dx[tsq_pkg::DELTA_W-1] ? -q_data.dx : q_data.dx;
  assign ady = q_data.dy[tsq_pkg::DELTA_W-1] ? -q_data.dy : q_data.dy;

  // shared multiplier
  always_comb begin
    case (state)
      tsq_pkg::CORE_SQX:  begin mul_a = mx[UW-1:0]; mul_b = mx[UW-1:0]; end
      tsq_pkg::CORE_SQY:  begin mul_a = my[UW-1:0]; mul_b = my[UW-1:0]; end
      tsq_pkg::CORE_MULX: begin mul_a = qy;         mul_b = width;      end
      default:            begin mul_a = qx;         mul_b = width;      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // round half away from zero on the magnitude, then drop 31 low bits (30 fraction bits of u, 1 to halve the width)
  assign rnd     = {1'b0, prod} + (tsq_pkg::PROD_W + 1)'(64'd1 << tsq_pkg::UNIT_FRAC);
  assign ofs_mag = rnd[tsq_pkg::PROD_W:tsq_pkg::UNIT_FRAC+1];

  assign sq_rem_sh = {sq_rem[tsq_pkg::SQ_REM_W-3:0], sq_n[tsq_pkg::SUMSQ_W-1 -: 2]};
  assign sq_trial  = {1'b0, root, 2'b01};
  assign rx_sh     = {remx, lowx[tsq_pkg::NUM_LOW_W-1]};
  assign ry_sh     = {remy, lowy[tsq_pkg::NUM_LOW_W-1]};
  assign numx = {1'b0, mx[UW-1:0], {tsq_pkg::UNIT_FRAC{1'b0}}}
              + tsq_pkg::NUM_W'(root >> 1);
  assign numy = {1'b0, my[UW-1:0], {tsq_pkg::UNIT_FRAC{1'b0}}}
              + tsq_pkg::NUM_W'(root >> 1);

  always_comb begin
    state_next = state;
    case (state)
      tsq_pkg::CORE_IDLE: if (!q_empty) state_next = tsq_pkg::CORE_NORM;
      tsq_pkg::CORE_NORM: begin
        if (mor[MW-1] || (mor[MW-2] && !mor[MW-1])) begin
          state_next = tsq_pkg::CORE_SQX;
        end
      end
      tsq_pkg::CORE_SQX:  state_next = tsq_pkg::CORE_SQY;
      tsq_pkg::CORE_SQY:  state_next = tsq_pkg::CORE_SQRT;
      tsq_pkg::CORE_SQRT: begin
        if (cnt == tsq_pkg::STEP_CNT_W'(tsq_pkg::SQRT_STEPS - 1)) begin
          state_next = tsq_pkg::CORE_DSET;
        end
      end
      tsq_pkg::CORE_DSET: state_next = tsq_pkg::CORE_DIV;
      tsq_pkg::CORE_DIV: begin
        if (cnt == tsq_pkg::STEP_CNT_W'(tsq_pkg::DIV_STEPS - 1)) begin
          state_next = tsq_pkg::CORE_MULX;
        end
      end
      tsq_pkg::CORE_MULX: state_next = tsq_pkg::CORE_MULY;
      tsq_pkg::CORE_MULY: state_next = tsq_pkg::CORE_OFS;
      tsq_pkg::CORE_OFS:  state_next = tsq_pkg::CORE_DONE;
      tsq_pkg::CORE_DONE: if (job_take) state_next = tsq_pkg::CORE_IDLE;
      default:            state_next = tsq_pkg::CORE_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    job_valid = 1'b0;
    case (state)
      tsq_pkg::CORE_IDLE: q_pop     = !q_empty;
      tsq_pkg::CORE_DONE: job_valid = 1'b1;
      default: ;
    endcase
  end

  assign job = '{x0: x0, y0: y0, x1: x1, y1: y1, ox: ox, oy: oy, color: color};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsq_pkg::CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tsq_pkg::CORE_IDLE: begin
        x0    <= q_data.x0;
        y0    <= q_data.y0;
        x1    <= q_data.x1;
        y1    <= q_data.y1;
        width <= q_data.width;
        color <= q_data.color;
        nx    <= q_data.dx[tsq_pkg::DELTA_W-1];
        ny    <= q_data.dy[tsq_pkg::DELTA_W-1];
        mx    <= adx[MW-1:0];
        my    <= ady[MW-1:0];
      end
      tsq_pkg::CORE_NORM: begin
        if (mor[MW-1]) begin
          mx <= mx >> 1;
          my <= my >> 1;
        end else if (mor[MW-1 -: 10] == '0) begin
          mx <= mx << 8;
          my <= my << 8;
        end else if (!mor[MW-2]) begin
          mx <= mx << 1;
          my <= my << 1;
        end
      end
      tsq_pkg::CORE_SQX: acc <= tsq_pkg::SUMSQ_W'(mul_p);
      tsq_pkg::CORE_SQY: begin
        sq_n   <= acc + tsq_pkg::SUMSQ_W'(mul_p);
        sq_rem <= '0;
        root   <= '0;
        cnt    <= '0;
      end
      tsq_pkg::CORE_SQRT: begin
        sq_n <= sq_n << 2;
        cnt  <= cnt + 1'b1;
        if (sq_rem_sh >= sq_trial) begin
          sq_rem <= sq_rem_sh - sq_trial;
          root   <= {root[tsq_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem <= sq_rem_sh;
          root   <= {root[tsq_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      tsq_pkg::CORE_DSET: begin
        remx <= tsq_pkg::ROOT_W'(numx[tsq_pkg::NUM_W-1:tsq_pkg::NUM_LOW_W]);
        remy <= tsq_pkg::ROOT_W'(numy[tsq_pkg::NUM_W-1:tsq_pkg::NUM_LOW_W]);
        lowx <= numx[tsq_pkg::NUM_LOW_W-1:0];
        lowy <= numy[tsq_pkg::NUM_LOW_W-1:0];
        cnt  <= '0;
      end
      tsq_pkg::CORE_DIV: begin
        cnt  <= cnt + 1'b1;
        lowx <= lowx << 1;
        lowy <= lowy << 1;
        if (rx_sh >= {1'b0, root}) begin
          remx <= tsq_pkg::ROOT_W'(rx_sh - {1'b0, root});
          qx   <= {qx[UW-2:0], 1'b1};
        end else begin
          remx <= rx_sh[tsq_pkg::ROOT_W-1:0];
          qx   <= {qx[UW-2:0], 1'b0};
        end
        if (ry_sh >= {1'b0, root}) begin
          remy <= tsq_pkg::ROOT_W'(ry_sh - {1'b0, root});
          qy   <= {qy[UW-2:0], 1'b1};
        end else begin
          remy <= ry_sh[tsq_pkg::ROOT_W-1:0];
          qy   <= {qy[UW-2:0], 1'b0};
        end
      end
      tsq_pkg::CORE_MULX: prod <= mul_p;
      tsq_pkg::CORE_MULY: begin
        // ox = half width times -uy
        ox   <= ny ? ofs_mag : -ofs_mag;
        prod <= mul_p;
      end
      tsq_pkg::CORE_OFS: oy <= nx ? -ofs_mag : ofs_mag;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* sv/tsq_emit.sv */
// Vertex sequencer: walks A0 B0 A1 B0 B1 A1 from one job into the output
// register. Depends on tsq_pkg and tsq_if.
`default_nettype none
module tsq_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              core_valid,
  input  tsq_pkg::tsq_job_t core_job,
  output logic              take,
  tsq_vtx_if.source         vtx
);
  tsq_pkg::tsq_job_t job;
  logic job_valid;
  logic [tsq_pkg::VTX_IDX_W-1:0] idx;
  logic out_valid;
  logic load_out, at_last, use_end, plus;

  assign load_out = job_valid && (!out_valid || vtx.ready);
  assign at_last  = (idx == tsq_pkg::VTX_LAST);
  assign take     = core_valid && (!job_valid || (load_out && at_last));
  assign use_end  = tsq_pkg::VTX_END_MASK[idx];
  assign plus     = tsq_pkg::VTX_PLUS_MASK[idx];
  assign vtx.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        idx       <= at_last ? '0 : idx + 1'b1;
      end else if (vtx.ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        job_valid <= 1'b1;
      end else if (load_out && at_last) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job <= core_job;
    end
    if (load_out) begin
      vtx.vertex_x    <= tsq_pkg::sat_add(use_end ? job.x1 : job.x0, job.ox, !plus);
      vtx.vertex_y    <= tsq_pkg::sat_add(use_end ? job.y1 : job.y0, job.oy, !plus);
      vtx.out_red     <= job.color.red;
      vtx.out_green   <= job.color.green;
      vtx.out_blue    <= job.color.blue;
      vtx.out_alpha   <= job.color.alpha;
      vtx.last_vertex <= at_last;
    end
  end
endmodule
`default_nettype wire

/* sv/tsq_checker.sv */
// Port-level checks for the tessellator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module tsq_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [63:0] out_color,
  input logic        out_last
);
  logic [2:0]  beat_cnt;
  logic [63:0] quad_color;
  logic        out_beat;

  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_cnt <= '0;
    end else if (out_beat) begin
      beat_cnt <= out_last ? '0 : beat_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat && (beat_cnt == '0)) begin
      quad_color <= out_color;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("vertex beat changed while stalled");

  a_last_sixth: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> (out_last == (beat_cnt == 3'd5)))
    else $error("last_vertex not on sixth beat");

  a_quad_color: assert property (@(posedge clk) disable iff (rst)
    out_beat && (beat_cnt != '0) |-> (out_color == quad_color))
    else $error("color changed within a quad");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("vertex beat right after reset");
endmodule

bind thick_segment_quad_tessellator tsq_checker u_tsq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (vtx.valid),
  .out_ready (vtx.ready),
  .out_x     (vtx.vertex_x),
  .out_y     (vtx.vertex_y),
  .out_color ({vtx.out_red, vtx.out_green, vtx.out_blue, vtx.out_alpha}),
  .out_last  (vtx.last_vertex)
);
`default_nettype wire
